FILE: hdl/afs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants for the animation frame sequencer: request
// codes, register indexes, play modes and the transaction structs.
// ----------------------------------------------------------------------------
package afs_pkg;

  // fixed field widths of the transaction ports
  localparam int FRAME_W = 4;
  localparam int FIELD_W = 16;
  localparam int SPEED_W = 12;
  localparam int COUNT_W = 5;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_PLAY = 2'd1,
    REQ_STOP = 2'd2,
    REQ_TICK = 2'd3
  } req_type_e;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd2;

  // play modes, any mode with bit 1 set bounces
  localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;

  // register reset values
  localparam logic [MODE_W-1:0]  PLAY_MODE_RST   = MODE_ONCE;
  localparam logic [SPEED_W-1:0] SPEED_SCALE_RST = 12'd256;
  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 5'd1;

  typedef struct packed {
    logic [MODE_W-1:0]  play_mode;
    logic [SPEED_W-1:0] speed_scale;
    logic [COUNT_W-1:0] frame_count;
  } afs_cfg_t;

  typedef struct packed {
    req_type_e          req_type;
    logic [FRAME_W-1:0] frame_index;
    logic [FIELD_W-1:0] duration;
    logic [FIELD_W-1:0] elapsed;
  } afs_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] current_frame;
    logic               playing;
    logic               reversing;
    logic               advanced;
  } afs_res_t;

endpackage

FILE: hdl/afs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_engine
// Playback state, duration table and the combinational step logic. Each
// accepted transaction updates the state and yields its result in the
// same cycle.
// ----------------------------------------------------------------------------
module afs_engine
  import afs_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int TIME_BITS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  afs_req_t req_i,
  input  afs_cfg_t cfg_i,
  output afs_res_t res_o
);

  // only frames the 4-bit index can reach are stored
  localparam int DEPTH = (MAX_FRAMES < 16) ? MAX_FRAMES : 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DUR_W = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
  localparam int ACC_W = TIME_BITS + 8;
  localparam int MUL_W = DUR_W + SPEED_W;
  localparam int CMP_W = ACC_W + 8;
  localparam logic [COUNT_W-1:0] DEPTH_N = COUNT_W'(DEPTH);
  localparam logic [ACC_W-1:0]   ACC_MAX = '1;

  logic [DUR_W-1:0]   dur_mem [DEPTH];
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [ACC_W-1:0]   accum_q, accum_d;
  logic               active_q, active_d;
  logic               backward_q, backward_d;

  logic [COUNT_W-1:0] clip_n;
  logic [FRAME_W-1:0] last_frame;
  logic [FRAME_W-1:0] frame_sat;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [DUR_W-1:0]   dur_rd;
  logic [MUL_W-1:0]   need;
  logic               reached;
  logic               at_last;
  logic               stepped;
  logic               load_ok;

  // clip length, clamped to 1..DEPTH
  always_comb begin
    clip_n = (cfg_i.frame_count == '0) ? COUNT_W'(1) : cfg_i.frame_count;
    if (clip_n > DEPTH_N) begin
      clip_n = DEPTH_N;
    end
    last_frame = FRAME_W'(clip_n - COUNT_W'(1));
  end

  // tick datapath: saturate frame, accumulate, scale duration and compare
  assign frame_sat = ({1'b0, frame_q} >= clip_n) ? last_frame : frame_q;
  assign acc_sum   = {1'b0, accum_q} + (ACC_W + 1)'(req_i.elapsed[DUR_W-1:0]);
  assign acc_sat   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign dur_rd    = dur_mem[frame_sat[IDX_W-1:0]];
  assign need      = MUL_W'(dur_rd) * MUL_W'(cfg_i.speed_scale);
  assign reached   = {acc_sat, 8'b0} >= CMP_W'(need);
  assign at_last   = (frame_sat == last_frame);
  assign load_ok   = ({1'b0, req_i.frame_index} < DEPTH_N);

  // next state per request
  always_comb begin
    frame_d    = frame_q;
    accum_d    = accum_q;
    active_d   = active_q;
    backward_d = backward_q;
    stepped    = 1'b0;
    unique case (req_i.req_type)
      REQ_LOAD: begin
      end
      REQ_PLAY: begin
        frame_d    = ({1'b0, req_i.frame_index} < clip_n) ? req_i.frame_index : last_frame;
        accum_d    = '0;
        backward_d = 1'b0;
        active_d   = 1'b1;
      end
      REQ_STOP: begin
        active_d = 1'b0;
        frame_d  = last_frame;
      end
      REQ_TICK: begin
        if (active_q) begin
          frame_d = frame_sat;
          accum_d = acc_sat;
          if (reached) begin
            stepped = 1'b1;
            accum_d = '0;
            if (cfg_i.play_mode == MODE_ONCE) begin
              if (at_last) begin
                active_d = 1'b0;
              end else begin
                frame_d = frame_sat + FRAME_W'(1);
              end
            end else if (cfg_i.play_mode == MODE_LOOP) begin
              frame_d = at_last ? '0 : frame_sat + FRAME_W'(1);
            end else if (!backward_q) begin
              // bounce at the top: hold the frame, flip direction
              if (at_last) begin
                backward_d = 1'b1;
              end else begin
                frame_d = frame_sat + FRAME_W'(1);
              end
            end else begin
              // bounce at frame zero likewise
              if (frame_sat == '0) begin
                backward_d = 1'b0;
              end else begin
                frame_d = frame_sat - FRAME_W'(1);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.current_frame = frame_d;
  assign res_o.playing       = active_d;
  assign res_o.reversing     = backward_d;
  assign res_o.advanced      = stepped;

  // playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q    <= '0;
      accum_q    <= '0;
      active_q   <= 1'b0;
      backward_q <= 1'b0;
    end else if (step_i) begin
      frame_q    <= frame_d;
      accum_q    <= accum_d;
      active_q   <= active_d;
      backward_q <= backward_d;
    end
  end

  // duration table, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (step_i && (req_i.req_type == REQ_LOAD) && load_ok) begin
      dur_mem[req_i.frame_index[IDX_W-1:0]] <= req_i.duration[DUR_W-1:0];
    end
  end

endmodule

FILE: hdl/animation_frame_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_frame_sequencer_top
// Sprite animation frame sequencer: duration table, playback state and
// an output register with a skid stage.
// ----------------------------------------------------------------------------
// the result is registered in the output register, via the skid entry when stalled
// throughput: one transaction per cycle while in_stall_o is low
// a skid entry lets one more transaction be accepted while the output stalls
// reset clears playback state and loads the register defaults; the duration
// table holds no value until loaded
module animation_frame_sequencer_top
  import afs_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int TIME_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input transaction
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [FRAME_W-1:0]    frame_index_i,
  input  logic [FIELD_W-1:0]    duration_i,
  input  logic [FIELD_W-1:0]    elapsed_i,
  // result transaction
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FRAME_W-1:0]    current_frame_o,
  output logic                  playing_o,
  output logic                  reversing_o,
  output logic                  advanced_o
);

  afs_cfg_t cfg_q;
  afs_req_t req;
  afs_res_t res;
  afs_res_t out_q, out_d;
  afs_res_t skid_q, skid_d;
  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  logic     in_fire;
  logic     out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.play_mode   <= PLAY_MODE_RST;
      cfg_q.speed_scale <= SPEED_SCALE_RST;
      cfg_q.frame_count <= FRAME_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PLAY_MODE:   cfg_q.play_mode   <= cfg_data_i[MODE_W-1:0];
        CFG_SPEED_SCALE: cfg_q.speed_scale <= cfg_data_i[SPEED_W-1:0];
        CFG_FRAME_COUNT: cfg_q.frame_count <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign req.req_type    = req_type_e'(req_type_i);
  assign req.frame_index = frame_index_i;
  assign req.duration    = duration_i;
  assign req.elapsed     = elapsed_i;

  afs_engine #(
    .MAX_FRAMES(MAX_FRAMES),
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_fire),
    .req_i (req),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  // output register with skid entry
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign current_frame_o = out_q.current_frame;
  assign playing_o       = out_q.playing;
  assign reversing_o     = out_q.reversing;
  assign advanced_o      = out_q.advanced;

  // skid entry only holds data behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // accepted transaction against a stalled output lands in the skid entry
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("transaction lost behind stalled output");

  // a drained skid entry moves into the output register
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry did not drain");

  // only a tick can take a frame step
  a_step_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.advanced) |-> (req.req_type == REQ_TICK))
    else $error("frame step on a non-tick transaction");

endmodule
